>>> rtl/core/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// Holds the transfer payload structs, token kinds and character codes.
// No dependencies.
package clt_pkg;

	localparam int LINE_LENGTH = 4096;
	localparam int START_W = 12;
	localparam int LEN_W = 13;
	localparam logic [START_W-1:0] START_MAX = START_W'(LINE_LENGTH - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LENGTH);

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_NUMBER  = 4'd1,
		KIND_STRING  = 4'd2,
		KIND_SEMI    = 4'd3,
		KIND_DOLLAR  = 4'd4,
		KIND_BAR     = 4'd5,
		KIND_OPEN    = 4'd6,
		KIND_CLOSE   = 4'd7,
		KIND_UNKNOWN = 4'd8,
		KIND_END     = 4'd9
	} tok_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_IDENT  = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_STRING = 4'b1000
	} scan_mode_t;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	typedef struct packed {
		logic       operation;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [START_W-1:0] start_pos;
		logic [LEN_W-1:0]   token_len;
		logic               last_in_run;
	} tok_t;

endpackage

>>> rtl/core/command_line_tokenizer_core.sv
// Command line tokenizer core: scans one character per transfer and emits tokens.
// Depends on clt_pkg for payload structs, token kinds and character codes.
//
// The block takes one character (or the end-of-line marker) per cycle while not
// stalled and returns zero, one or two tokens for it, each with kind, start position
// and length. A new item is taken in the cycle after the previous one whenever the
// token register is empty or its last token leaves in that cycle. An item that
// yields two tokens (a word closed by a punctuation or unknown character, or a flush
// followed by END) holds off the next item until its second token leaves, as there
// is a single token output port. The first token appears in the cycle after the item
// is taken. The end marker returns all scan state to that of a fresh line. Start
// positions saturate at LINE_LENGTH - 1, lengths and the position count at the line length.
module command_line_tokenizer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  clt_pkg::cmd_t cmd_data,
	output logic          tok_valid,
	input  logic          tok_stall,
	output clt_pkg::tok_t tok_data
);
	import clt_pkg::*;

	scan_mode_t         mode_q, nxt_mode;
	logic [START_W-1:0] start_q, nxt_start;
	logic [LEN_W-1:0]   len_q, nxt_len;
	logic [LEN_W-1:0]   char_pos_q, nxt_pos;

	tok_t slot0_q, slot1_q;
	logic valid0_q, valid1_q;

	logic               accept, pop;
	logic [7:0]         c;
	logic               is_alpha, is_digit, is_space;
	logic [START_W-1:0] pos;
	logic [LEN_W-1:0]   len_inc;
	logic [START_W-1:0] start_inc;
	logic               handled;
	logic               flush, single;
	tok_t               flush_tok, single_tok;
	tok_t               res_a, res_b;

	function automatic tok_t make_tok(tok_kind_t k, logic [START_W-1:0] s,
			logic [LEN_W-1:0] n);
		tok_t t;
		t.kind = k;
		t.start_pos = s;
		t.token_len = n;
		t.last_in_run = 1'b0;
		return t;
	endfunction

	assign pop = valid0_q && !tok_stall;
	assign cmd_stall = valid0_q && !(pop && !valid1_q);
	assign accept = cmd_valid && !cmd_stall;
	assign tok_valid = valid0_q;
	assign tok_data = slot0_q;

	assign c = cmd_data.ch;
	assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	assign is_digit = c >= 8'h30 && c <= 8'h39;
	assign is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	assign pos = (char_pos_q > LEN_W'(START_MAX)) ? START_MAX : char_pos_q[START_W-1:0];
	assign len_inc = (len_q >= LEN_MAX) ? LEN_MAX : len_q + LEN_W'(1);
	assign start_inc = (start_q == START_MAX) ? START_MAX : start_q + START_W'(1);

	always_comb begin
		nxt_mode = mode_q;
		nxt_start = start_q;
		nxt_len = len_q;
		nxt_pos = (char_pos_q >= LEN_MAX) ? LEN_MAX : char_pos_q + LEN_W'(1);
		handled = 1'b0;
		flush = 1'b0;
		single = 1'b0;
		flush_tok = make_tok(KIND_UNKNOWN, start_q, LEN_W'(1));
		single_tok = make_tok(KIND_UNKNOWN, pos, LEN_W'(1));
		if (cmd_data.operation == OP_END) begin
			flush = mode_q != MODE_IDLE;
			if (mode_q == MODE_IDENT) begin
				flush_tok = make_tok(KIND_IDENT, start_q, len_q);
			end else if (mode_q == MODE_NUMBER) begin
				flush_tok = make_tok(KIND_NUMBER, start_q, len_q);
			end
			single = 1'b1;
			single_tok = make_tok(KIND_END, '0, '0);
			nxt_mode = MODE_IDLE;
			nxt_start = '0;
			nxt_len = '0;
			nxt_pos = '0;
		end else begin
			unique case (mode_q)
				MODE_STRING: begin
					handled = 1'b1;
					if (c == CH_QUOTE) begin
						flush = 1'b1;
						flush_tok = make_tok(KIND_STRING, start_inc, len_q);
						nxt_mode = MODE_IDLE;
						nxt_len = '0;
					end else begin
						nxt_len = len_inc;
					end
				end
				MODE_IDENT: begin
					if (is_alpha || is_digit || c == CH_UNDER) begin
						nxt_len = len_inc;
						handled = 1'b1;
					end else begin
						flush = 1'b1;
						flush_tok = make_tok(KIND_IDENT, start_q, len_q);
						nxt_mode = MODE_IDLE;
						nxt_len = '0;
					end
				end
				MODE_NUMBER: begin
					if (is_digit || c == CH_DOT) begin
						nxt_len = len_inc;
						handled = 1'b1;
					end else begin
						flush = 1'b1;
						flush_tok = make_tok(KIND_NUMBER, start_q, len_q);
						nxt_mode = MODE_IDLE;
						nxt_len = '0;
					end
				end
				MODE_IDLE: begin
				end
				default: begin
				end
			endcase
			if (!handled) begin
				if (is_space) begin
				end else if (is_alpha) begin
					nxt_mode = MODE_IDENT;
					nxt_start = pos;
					nxt_len = LEN_W'(1);
				end else if (is_digit) begin
					nxt_mode = MODE_NUMBER;
					nxt_start = pos;
					nxt_len = LEN_W'(1);
				end else if (c == CH_QUOTE) begin
					nxt_mode = MODE_STRING;
					nxt_start = pos;
					nxt_len = '0;
				end else begin
					single = 1'b1;
					case (c)
						CH_SEMI:   single_tok.kind = KIND_SEMI;
						CH_DOLLAR: single_tok.kind = KIND_DOLLAR;
						CH_BAR:    single_tok.kind = KIND_BAR;
						CH_OPEN:   single_tok.kind = KIND_OPEN;
						CH_CLOSE:  single_tok.kind = KIND_CLOSE;
						default:   single_tok.kind = KIND_UNKNOWN;
					endcase
				end
			end
		end
		res_a = flush ? flush_tok : single_tok;
		res_a.last_in_run = !(flush && single);
		res_b = single_tok;
		res_b.last_in_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			start_q <= '0;
			len_q <= '0;
			char_pos_q <= '0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			start_q <= nxt_start;
			len_q <= nxt_len;
			char_pos_q <= nxt_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= 1'b0;
			valid1_q <= 1'b0;
		end else if (accept) begin
			valid0_q <= flush || single;
			valid1_q <= flush && single;
		end else if (pop) begin
			valid0_q <= valid1_q;
			valid1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot0_q <= res_a;
			slot1_q <= res_b;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid1_q |-> valid0_q)
		else $error("second token held without a first");

	a_accept_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !valid1_q)
		else $error("item taken while two tokens are pending");

	a_not_last_has_next: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_data.last_in_run |-> valid1_q)
		else $error("token marked not last with nothing behind it");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.kind == KIND_END |->
			tok_data.start_pos == '0 && tok_data.token_len == '0 && tok_data.last_in_run)
		else $error("END token carries bad fields");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_data.operation == OP_END |=>
			mode_q == MODE_IDLE && char_pos_q == '0 && len_q == '0)
		else $error("scan state not cleared after end of line");

endmodule

>>> verif/command_line_tokenizer_checker.sv
// Token checker for the command line tokenizer: follows both transfer channels,
// computes the tokens each accepted command must produce and compares them in order.
// Depends on clt_pkg for the payload structs, token kinds, scan modes and character codes.
module command_line_tokenizer_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  clt_pkg::cmd_t cmd_data,
	input  logic          tok_valid,
	input  logic          tok_stall,
	input  clt_pkg::tok_t tok_data,
	output int            mismatches,
	output int            pending_tokens,
	output int            tokens_seen
);
	import clt_pkg::*;

	scan_mode_t         mode;
	logic [START_W-1:0] word_start;
	logic [LEN_W-1:0]   word_len;
	logic [LEN_W-1:0]   next_pos;
	tok_t               awaited_tokens[$];
	tok_t               batch[0:1];
	int                 batch_n;
	int                 err_count;
	int                 compared;

	function automatic logic [START_W-1:0] clamp_start(input int p);
		return (p > int'(START_MAX)) ? START_MAX : START_W'(p);
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input int n);
		return (n > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(n);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void note_token(input tok_kind_t k, input logic [START_W-1:0] s,
			input logic [LEN_W-1:0] l);
		tok_t t;
		t.kind = k;
		t.start_pos = s;
		t.token_len = l;
		t.last_in_run = 1'b0;
		batch[batch_n] = t;
		batch_n++;
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			err_count++;
		end
	endfunction

	task automatic restart_line();
		mode = MODE_IDLE;
		word_start = '0;
		word_len = '0;
		next_pos = '0;
	endtask

	task automatic tokenize_cmd(input cmd_t cmd);
		logic [START_W-1:0] pos;
		logic [7:0]         c;
		logic               absorbed;
		tok_kind_t          k;
		tok_t               t;
		batch_n = 0;
		c = cmd.ch;
		if (cmd.operation == OP_END) begin
			case (mode)
				MODE_IDENT:  note_token(KIND_IDENT, word_start, word_len);
				MODE_NUMBER: note_token(KIND_NUMBER, word_start, word_len);
				MODE_STRING: note_token(KIND_UNKNOWN, word_start, LEN_W'(1));
				default: ;
			endcase
			note_token(KIND_END, '0, '0);
			restart_line();
		end else begin
			pos = clamp_start(int'(next_pos));
			absorbed = 1'b0;
			case (mode)
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						note_token(KIND_STRING, clamp_start(int'(word_start) + 1), word_len);
						mode = MODE_IDLE;
						word_len = '0;
					end else begin
						word_len = clamp_len(int'(word_len) + 1);
					end
					absorbed = 1'b1;
				end
				MODE_IDENT: begin
					if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
						word_len = clamp_len(int'(word_len) + 1);
						absorbed = 1'b1;
					end else begin
						note_token(KIND_IDENT, word_start, word_len);
						mode = MODE_IDLE;
						word_len = '0;
					end
				end
				MODE_NUMBER: begin
					if (is_numeral(c) || c == CH_DOT) begin
						word_len = clamp_len(int'(word_len) + 1);
						absorbed = 1'b1;
					end else begin
						note_token(KIND_NUMBER, word_start, word_len);
						mode = MODE_IDLE;
						word_len = '0;
					end
				end
				default: ;
			endcase
			if (!absorbed && !is_blank(c)) begin
				if (is_letter(c)) begin
					mode = MODE_IDENT;
					word_start = pos;
					word_len = LEN_W'(1);
				end else if (is_numeral(c)) begin
					mode = MODE_NUMBER;
					word_start = pos;
					word_len = LEN_W'(1);
				end else if (c == CH_QUOTE) begin
					mode = MODE_STRING;
					word_start = pos;
					word_len = '0;
				end else begin
					case (c)
						CH_SEMI:   k = KIND_SEMI;
						CH_DOLLAR: k = KIND_DOLLAR;
						CH_BAR:    k = KIND_BAR;
						CH_OPEN:   k = KIND_OPEN;
						CH_CLOSE:  k = KIND_CLOSE;
						default:   k = KIND_UNKNOWN;
					endcase
					note_token(k, pos, LEN_W'(1));
				end
			end
			next_pos = clamp_len(int'(next_pos) + 1);
		end
		for (int i = 0; i < batch_n; i++) begin
			t = batch[i];
			t.last_in_run = (i == batch_n - 1);
			awaited_tokens.push_back(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tok_t want;
		if (!arst_n) begin
			restart_line();
			awaited_tokens.delete();
			err_count = 0;
			compared = 0;
			mismatches <= 0;
			pending_tokens <= 0;
			tokens_seen <= 0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (awaited_tokens.size() == 0) begin
					$display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
						$time, tok_data.kind, tok_data.start_pos, tok_data.token_len);
					err_count++;
				end else begin
					want = awaited_tokens.pop_front();
					check_field("kind", int'(want.kind), int'(tok_data.kind));
					check_field("start_pos", int'(want.start_pos), int'(tok_data.start_pos));
					check_field("token_len", int'(want.token_len), int'(tok_data.token_len));
					check_field("last_in_run", int'(want.last_in_run), int'(tok_data.last_in_run));
				end
				compared++;
			end
			if (cmd_valid && !cmd_stall) begin
				tokenize_cmd(cmd_data);
			end
			mismatches <= err_count;
			pending_tokens <= awaited_tokens.size();
			tokens_seen <= compared;
		end
	end

endmodule

>>> verif/command_line_tokenizer_core_tb.sv
// Testbench top for command_line_tokenizer_core: drives random command lines with gaps
// and output stalls, and reports the verdict.
// Depends on clt_pkg, the core and command_line_tokenizer_checker.
module command_line_tokenizer_core_tb;
	import clt_pkg::*;

	localparam int ITEM_TARGET = 1400;
	localparam int QUIET_TAIL = 150;
	localparam int LONG_HOLD = 200;
	localparam int HOLD_LINE = 15;
	localparam int DRAIN_LINE = 30;
	localparam int DRAIN_EXTRA = 20;
	localparam int LIMIT = 1500000;

	localparam int CLS_LETTER = 0;
	localparam int CLS_DIGIT = 1;
	localparam int CLS_WORD = 2;
	localparam int CLS_NUMCH = 3;
	localparam int CLS_BLANK = 4;
	localparam int CLS_PUNCT = 5;
	localparam int CLS_TEXT = 6;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_data;
	logic tok_valid;
	logic tok_stall;
	tok_t tok_data;

	int mismatches;
	int pending_tokens;
	int tokens_seen;
	int cycles = 0;
	int items_sent = 0;
	int lines_sent = 0;
	bit quiet = 1'b0;
	bit tx_idle_en = 1'b1;
	bit hold_req = 1'b0;

	command_line_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data)
	);

	command_line_tokenizer_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data),
		.mismatches(mismatches),
		.pending_tokens(pending_tokens),
		.tokens_seen(tokens_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] pick_char(input int cls);
		logic [7:0] c;
		case (cls)
			CLS_LETTER: c = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
				: 8'($urandom_range(8'h61, 8'h7A));
			CLS_DIGIT: c = 8'($urandom_range(8'h30, 8'h39));
			CLS_WORD: begin
				case ($urandom_range(0, 3))
					0, 1:    c = pick_char(CLS_LETTER);
					2:       c = pick_char(CLS_DIGIT);
					default: c = CH_UNDER;
				endcase
			end
			CLS_NUMCH: c = ($urandom_range(0, 3) == 0) ? CH_DOT : pick_char(CLS_DIGIT);
			CLS_BLANK: begin
				c = 8'($urandom_range(8, 13));
				if (c == 8'd8) c = 8'h20;
			end
			CLS_PUNCT: begin
				case ($urandom_range(0, 4))
					0:       c = CH_SEMI;
					1:       c = CH_DOLLAR;
					2:       c = CH_BAR;
					3:       c = CH_OPEN;
					default: c = CH_CLOSE;
				endcase
			end
			default: begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
			end
		endcase
		return c;
	endfunction

	task automatic send_cmd(input logic op, input logic [7:0] c);
		cmd_t item;
		int   gap;
		item.operation = op;
		item.ch = c;
		cmd_valid <= 1'b1;
		cmd_data <= item;
		do @(posedge clk); while (cmd_stall);
		items_sent++;
		if (op == OP_END) lines_sent++;
		if (tx_idle_en && !quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_cmd(OP_CHAR, s[i]);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens != 0);
	endtask

	task automatic send_random_line();
		int parts;
		int n;
		parts = $urandom_range(0, 8);
		for (int i = 0; i < parts; i++) begin
			n = $urandom_range(0, 6);
			case ($urandom_range(0, 6))
				0: begin
					send_cmd(OP_CHAR, pick_char(CLS_LETTER));
					repeat (n) send_cmd(OP_CHAR, pick_char(CLS_WORD));
				end
				1: begin
					send_cmd(OP_CHAR, pick_char(CLS_DIGIT));
					repeat (n) send_cmd(OP_CHAR, pick_char(CLS_NUMCH));
				end
				2: begin
					send_cmd(OP_CHAR, CH_QUOTE);
					repeat (n) send_cmd(OP_CHAR, pick_char(CLS_TEXT));
					if ($urandom_range(0, 7) != 0) send_cmd(OP_CHAR, CH_QUOTE);
				end
				3: send_cmd(OP_CHAR, pick_char(CLS_PUNCT));
				4: repeat (1 + n % 3) send_cmd(OP_CHAR, pick_char(CLS_BLANK));
				5: send_cmd(OP_CHAR, 8'($urandom_range(0, 255)));
				default: ;
			endcase
			if ($urandom_range(0, 1)) send_cmd(OP_CHAR, pick_char(CLS_BLANK));
		end
		send_cmd(OP_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		tok_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			logic lvl;
			int   n;
			if (hold_req) begin
				lvl = 1'b1;
				n = LONG_HOLD;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				lvl = 1'b1;
				n = $urandom_range(1, 15);
			end else begin
				lvl = 1'b0;
				n = quiet ? 1 : $urandom_range(1, 20);
			end
			tok_stall <= lvl;
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		int line;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every token kind, then an empty line and an open string.
		send_text("ab_9 3.1\t\"q r\";$|()");
		send_cmd(OP_CHAR, 8'hFF);
		send_cmd(OP_END, 8'h00);
		send_cmd(OP_END, 8'hFF);
		send_cmd(OP_CHAR, CH_QUOTE);
		send_cmd(OP_END, 8'h5A);
		send_cmd(OP_CHAR, 8'h78);
		send_cmd(OP_END, 8'hA5);

		line = 0;
		while (items_sent < ITEM_TARGET) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			quiet = (items_sent > ITEM_TARGET - QUIET_TAIL);
			if (line == HOLD_LINE) hold_req = 1'b1;
			if (line == DRAIN_LINE) wait_drained();
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 12)) send_cmd(OP_CHAR, 8'($urandom_range(0, 255)));
				send_cmd(OP_END, 8'($urandom_range(0, 255)));
			end else begin
				send_random_line();
			end
			line++;
		end

		wait_drained();
		repeat (DRAIN_EXTRA) @(posedge clk);
		$display("Run covered %0d commands in %0d lines, with long output stalls and a full drain.",
			items_sent, lines_sent);
		$display("%0d tokens were compared with the predicted stream.", tokens_seen);
		if (mismatches == 0 && pending_tokens == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/clt_pkg.sv
rtl/core/command_line_tokenizer_core.sv
verif/command_line_tokenizer_checker.sv
verif/command_line_tokenizer_core_tb.sv
